[hw/rtl/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the signed decimal sorter
// Request codes, status codes, store sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int MaxEntries = 512;
	localparam int MaxDigits  = 64;
	localparam int IdxW       = $clog2(MaxEntries);
	localparam int CntW       = $clog2(MaxEntries + 1);
	localparam int HdrW       = 8;
	localparam int WordW      = 64;
	// one memory row holds header and all four digit words of one entry
	localparam int RowW       = HdrW + 4 * WordW;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_DONE
	} seq_state_t;

endpackage

[hw/rtl/sds_ram.sv]
// ----------------------------------------------------------------------------
// sds_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sds_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/signed_decimal_sorter.sv]
// ----------------------------------------------------------------------------
// signed_decimal_sorter: sorted store of signed BCD integers
// Keeps up to 512 numbers sorted in one RAM and answers reads by rank.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer when            Content
// s_axis    in   s_axis_tvalid & tready   request (append / read / clear)
// m_axis    out  m_axis_tvalid & tready   one result per request
//
// Sequence: append scans from the top of the store downward, one row per cycle,
// moving each larger entry up one place, then writes the new one. Read goes
// through the read state to the done state; clear and unused codes go straight
// to the done state. Reset empties the store at once (the count clears; rows
// are never read before being written). A stalled result holds in the output
// register and the next request waits until it leaves.
// ----------------------------------------------------------------------------
module signed_decimal_sorter (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// req_type[1:0], negative[2], digit_count[9:3], digits_word_3..0[265:10],
	// rank[274:266], zero fill to 280
	input  logic [279:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], out_negative[2], out_digit_count[9:3],
	// out_word_3..0[265:10], stored_count[275:266], zero fill to 280
	output logic [279:0] m_axis_tdata
);
	import sds_pkg::*;

	seq_state_t state_q, state_d;

	logic [CntW-1:0]  count_q;
	logic [IdxW-1:0]  ptr_q;      // row being read during scan
	logic [1:0]       req_q;
	logic [HdrW-1:0]  new_hdr_q;
	logic [WordW-1:0] new_w_q [4];
	logic [IdxW-1:0]  rank_q;
	logic             out_valid_q;
	logic [279:0]     out_data_q;

	logic            we;
	logic [IdxW-1:0] waddr, raddr;
	logic [RowW-1:0] wdata, rdata;

	sds_ram #(.Width(RowW), .Depth(MaxEntries)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// decode and normalize an incoming append
	logic [6:0]       in_cnt;
	logic [WordW-1:0] in_w [4];
	logic [WordW-1:0] in_raw [4];
	always_comb begin
		in_raw[3] = s_axis_tdata[73:10];
		in_raw[2] = s_axis_tdata[137:74];
		in_raw[1] = s_axis_tdata[201:138];
		in_raw[0] = s_axis_tdata[265:202];
		in_cnt = (s_axis_tdata[9:3] > 7'(MaxDigits)) ? 7'(MaxDigits) : s_axis_tdata[9:3];
		for (int j = 0; j < 4; j++) begin
			// digits kept in word j (0 = most significant word here)
			logic [6:0] keep;
			keep = (in_cnt > 7'(16 * j)) ? in_cnt - 7'(16 * j) : 7'd0;
			if (keep >= 7'd16) begin
				in_w[3-j] = in_raw[3-j];
			end else if (keep == 7'd0) begin
				in_w[3-j] = '0;
			end else begin
				in_w[3-j] = in_raw[3-j] & ~({WordW{1'b1}} >> (4 * keep));
			end
		end
	end

	// compare stored row against new number: true when stored ranks above
	logic [HdrW-1:0]  r_hdr;
	logic [4*WordW-1:0] r_dig, n_dig;
	logic             above;
	always_comb begin
		logic mag_gt, mag_lt;
		r_hdr = rdata[RowW-1 -: HdrW];
		r_dig = rdata[4*WordW-1:0];
		n_dig = {new_w_q[3], new_w_q[2], new_w_q[1], new_w_q[0]};
		if (r_hdr[6:0] != new_hdr_q[6:0]) begin
			mag_gt = r_hdr[6:0] > new_hdr_q[6:0];
			mag_lt = !mag_gt;
		end else begin
			mag_gt = r_dig > n_dig;
			mag_lt = r_dig < n_dig;
		end
		if (r_hdr[7] != new_hdr_q[7]) begin
			above = new_hdr_q[7];
		end else if (r_hdr[7]) begin
			above = mag_lt;
		end else begin
			above = mag_gt;
		end
	end

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// sequencer: scan reads row ptr; when the row ranks above, write it one up
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = ptr_q + IdxW'(1);
		wdata = rdata;
		raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (s_axis_tdata[1:0] == REQ_APPEND &&
					             count_q < CntW'(MaxEntries) && count_q != '0) begin
						state_d = S_SCAN;
						raddr = IdxW'(count_q - CntW'(1));
					end else if (s_axis_tdata[1:0] == REQ_READ &&
					             CntW'(s_axis_tdata[274:266]) < count_q) begin
						state_d = S_READ;
						raddr = s_axis_tdata[274:266];
					end else if (s_axis_tdata[1:0] == REQ_APPEND &&
					             count_q == '0) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (above) begin
					we = 1'b1;
					raddr = ptr_q - IdxW'(1);
					if (ptr_q == '0) begin
						state_d = S_SHIFT;
					end
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				we = 1'b1;
				wdata = {new_hdr_q, new_w_q[3], new_w_q[2], new_w_q[1], new_w_q[0]};
				state_d = S_DONE;
			end
			S_READ: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// empty store: start one below row 0 so the write lands at 0
						if (s_axis_tdata[1:0] == REQ_APPEND && count_q == '0) begin
							ptr_q <= IdxW'(0) - IdxW'(1);
						end else begin
							ptr_q <= IdxW'(count_q - CntW'(1));
						end
					end
				end
				S_SCAN: begin
					// not above: new entry goes at ptr+1, which stays in waddr
					if (above) begin
						ptr_q <= ptr_q - IdxW'(1);
					end
				end
				S_SHIFT: count_q <= count_q + CntW'(1);
				S_DONE: begin
					out_valid_q <= 1'b1;
					if (req_q == REQ_CLEAR) begin
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_axis_tdata[1:0];
			new_hdr_q <= {s_axis_tdata[2], in_cnt};
			for (int j = 0; j < 4; j++) begin
				new_w_q[j] <= in_w[j];
			end
			rank_q <= s_axis_tdata[274:266];
			out_data_q[265:0] <= '0;
			out_data_q[279:276] <= '0;
			if (s_axis_tdata[1:0] == REQ_APPEND && count_q >= CntW'(MaxEntries)) begin
				out_data_q[1:0] <= ST_FULL;
			end else if (s_axis_tdata[1:0] == REQ_READ &&
			             CntW'(s_axis_tdata[274:266]) >= count_q) begin
				out_data_q[1:0] <= ST_RANGE;
			end else begin
				out_data_q[1:0] <= ST_OK;
			end
		end else if (state_q == S_READ) begin
			out_data_q[2]     <= rdata[RowW-1];
			out_data_q[9:3]   <= rdata[RowW-2 -: 7];
			out_data_q[73:10] <= rdata[4*WordW-1 -: WordW];
			out_data_q[137:74] <= rdata[3*WordW-1 -: WordW];
			out_data_q[201:138] <= rdata[2*WordW-1 -: WordW];
			out_data_q[265:202] <= rdata[WordW-1:0];
		end else if (state_q == S_DONE) begin
			// count after this request: a clear reports zero
			out_data_q[275:266] <= (req_q == REQ_CLEAR) ? '0 : count_q;
		end
	end

	// assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxEntries)) else $error("count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> m_axis_tvalid) else $error("result missing");
	a_read_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (CntW'(rank_q) < count_q)) else $error("bad read rank");
endmodule
